[rtl/ipq_pkg.sv]
package ipq_pkg;

   // default capacity and the raw Q24.8 form of 1000000.0
   localparam int DEF_MAX_ENTRIES = 256;
   localparam logic signed [31:0] PRIO_LIMIT = 32'sd256000000;
   localparam int CSR_RESET = 256;

   // operation codes of the request channel
   typedef enum logic [2:0] {
      MODE_INSERT   = 3'd0,
      MODE_INCREASE = 3'd1,
      MODE_DECREASE = 3'd2,
      MODE_REMOVE   = 3'd3,
      MODE_QUERY    = 3'd4
   } mode_type;

   // command broadcast to every cell of the chain
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_POP
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic signed [31:0] prio;
   } cell_cmd_type;

endpackage

[rtl/ipq_cell.sv]
module ipq_cell #(
   parameter int IW = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ipq_pkg::cell_cmd_type cmd,
   input  logic [IW-1:0]        cmd_id,
   input  logic                 left_ge,
   input  logic                 left_valid,
   input  logic [IW-1:0]        left_id,
   input  logic signed [31:0]   left_prio,
   input  logic                 right_valid,
   input  logic [IW-1:0]        right_id,
   input  logic signed [31:0]   right_prio,
   input  logic                 hit_in,
   output logic                 valid,
   output logic [IW-1:0]        id,
   output logic signed [31:0]   prio,
   output logic                 ge,
   output logic                 hit_out
);
   import ipq_pkg::*;

   logic                valid_ff, valid_in;
   logic [IW-1:0]       id_ff, id_in;
   logic signed [31:0]  prio_ff, prio_in;

   // this cell stays in place on insert while it outranks the new entry
   assign ge      = valid_ff && (prio_ff > cmd.prio);
   // removal point seen at or before this cell
   assign hit_out = hit_in || (valid_ff && (id_ff == cmd_id));

   // choose between holding, taking the new entry or a neighbour
   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      prio_in  = prio_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (!ge) begin
               if (left_ge) begin
                  valid_in = 1'b1;
                  id_in    = cmd_id;
                  prio_in  = cmd.prio;
               end else begin
                  valid_in = left_valid;
                  id_in    = left_id;
                  prio_in  = left_prio;
               end
            end
         end
         CELL_DELETE, CELL_POP: begin
            if (hit_out) begin
               valid_in = right_valid;
               id_in    = right_id;
               prio_in  = right_prio;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      id_ff   <= id_in;
      prio_ff <= prio_in;
   end

   assign valid = valid_ff;
   assign id    = id_ff;
   assign prio  = prio_ff;

endmodule

[rtl/indexed_priority_queue.sv]
// Indexed priority queue: entries keyed by id, held in descending priority
// order (newest first among equals) in a chain of cells that shift by one
// place per cycle. After a request transfer the sequencer passes through its
// look and reply states for an insert, remove-highest, query or rejected
// request, and through its look, place and reply states for an increase or
// decrease. The place state is needed because the chain first closes the gap
// of the old entry and then opens a new one. A new request is taken in the
// cycle after the result is loaded into the output register, so a request is
// not taken before the previous one is through. While the previous result is
// still held in a stalled output register, the sequencer waits in its reply
// state and the request input stays stalled. The per-id priority store is
// read at the request transfer, and its data is used in the following cycle.
module indexed_priority_queue #(
   parameter int MAX_ENTRIES = ipq_pkg::DEF_MAX_ENTRIES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [8:0]         csr_active_entries,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic signed [10:0] req_entry_id,
   input  logic signed [31:0] req_new_priority,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_ok,
   output logic [7:0]         rsp_out_id,
   output logic signed [31:0] rsp_out_priority,
   output logic [8:0]         rsp_entry_count
);
   import ipq_pkg::*;

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [1:0] {S_IDLE, S_LOOK, S_PLACE, S_REPLY} state_type;

   state_type          state_ff;
   logic [8:0]         active_ff;
   logic [CW-1:0]      count_ff;
   logic               present_ff [MAX_ENTRIES];
   logic signed [31:0] prio_mem [MAX_ENTRIES];
   logic signed [31:0] cur_ff;
   logic [2:0]         mode_ff;
   logic [IW-1:0]      idx_ff;
   logic               idok_ff;
   logic signed [31:0] np_ff;
   logic               ok_ff;
   logic [7:0]         oid_ff;
   logic signed [31:0] opr_ff;
   logic               rsp_valid_ff;
   logic               rsp_ok_ff;
   logic [7:0]         rsp_id_ff;
   logic signed [31:0] rsp_prio_ff;
   logic [8:0]         rsp_count_ff;

   cell_cmd_type       cmd;
   logic [IW-1:0]      cmd_id;
   logic               c_valid [MAX_ENTRIES];
   logic [IW-1:0]      c_id    [MAX_ENTRIES];
   logic signed [31:0] c_prio  [MAX_ENTRIES];
   logic               c_ge    [MAX_ENTRIES];
   logic               c_hit   [MAX_ENTRIES];

   logic req_xfer, id_ok, pres, lim_ok;
   logic ins_ok, chg_ok, pop_ok, qry_ok, rsp_free;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // id check: non-negative, below the register and the capacity
   assign id_ok = !req_entry_id[10]
                  && ({2'b00, req_entry_id[9:0]} < {3'b000, active_ff})
                  && ({1'b0, req_entry_id[9:0]} < 11'(MAX_ENTRIES));

   // decide the operation once the stored priority is back
   assign pres   = idok_ff && present_ff[idx_ff];
   assign lim_ok = (np_ff < PRIO_LIMIT);
   assign ins_ok = (mode_ff == MODE_INSERT) && idok_ff && !present_ff[idx_ff] && lim_ok;
   assign chg_ok = pres && lim_ok
                   && (((mode_ff == MODE_INCREASE) && (np_ff > cur_ff))
                    || ((mode_ff == MODE_DECREASE) && (np_ff < cur_ff)));
   assign pop_ok = (mode_ff == MODE_REMOVE) && (count_ff != '0);
   assign qry_ok = (mode_ff == MODE_QUERY) && pres;

   // drive the command broadcast to the chain
   always_comb begin
      cmd.op   = CELL_HOLD;
      cmd.prio = np_ff;
      cmd_id   = idx_ff;
      if (state_ff == S_LOOK) begin
         if (ins_ok) begin
            cmd.op = CELL_INSERT;
         end else if (chg_ok) begin
            cmd.op = CELL_DELETE;
         end else if (pop_ok) begin
            cmd.op = CELL_POP;
         end
      end else if (state_ff == S_PLACE) begin
         cmd.op = CELL_INSERT;
      end
   end

   // chain of cells
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic               l_ge, l_valid, r_valid, h_in;
      logic [IW-1:0]      l_id, r_id;
      logic signed [31:0] l_prio, r_prio;
      if (i == 0) begin : g_first
         assign l_ge    = 1'b1;
         assign l_valid = 1'b0;
         assign l_id    = '0;
         assign l_prio  = '0;
         assign h_in    = (cmd.op == CELL_POP);
      end else begin : g_mid
         assign l_ge    = c_ge[i-1];
         assign l_valid = c_valid[i-1];
         assign l_id    = c_id[i-1];
         assign l_prio  = c_prio[i-1];
         assign h_in    = c_hit[i-1];
      end
      if (i == MAX_ENTRIES - 1) begin : g_last
         assign r_valid = 1'b0;
         assign r_id    = '0;
         assign r_prio  = '0;
      end else begin : g_inner
         assign r_valid = c_valid[i+1];
         assign r_id    = c_id[i+1];
         assign r_prio  = c_prio[i+1];
      end
      ipq_cell #(.IW(IW)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .cmd_id      (cmd_id),
         .left_ge     (l_ge),
         .left_valid  (l_valid),
         .left_id     (l_id),
         .left_prio   (l_prio),
         .right_valid (r_valid),
         .right_id    (r_id),
         .right_prio  (r_prio),
         .hit_in      (h_in),
         .valid       (c_valid[i]),
         .id          (c_id[i]),
         .prio        (c_prio[i]),
         .ge          (c_ge[i]),
         .hit_out     (c_hit[i])
      );
   end

   // per-id priority store: read at transfer, write on insert or change
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cur_ff <= prio_mem[req_entry_id[IW-1:0]];
      end
      if ((state_ff == S_LOOK) && (ins_ok || chg_ok)) begin
         prio_mem[idx_ff] <= np_ff;
      end
   end

   // sequencer, presence flags, count and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= 9'(CSR_RESET);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            present_ff[i] <= 1'b0;
         end
      end else begin
         if (csr_write) begin
            active_ff <= csr_active_entries;
         end
         // load a new result, or drop the one just transferred
         if ((state_ff == S_REPLY) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  state_ff <= S_LOOK;
               end
            end
            S_LOOK: begin
               ok_ff    <= ins_ok || chg_ok || pop_ok || qry_ok;
               oid_ff   <= pop_ok ? 8'(c_id[0]) : 8'd0;
               opr_ff   <= pop_ok ? c_prio[0] : (qry_ok ? cur_ff : 32'sd0);
               state_ff <= chg_ok ? S_PLACE : S_REPLY;
               if (ins_ok) begin
                  present_ff[idx_ff] <= 1'b1;
                  count_ff           <= count_ff + 1'b1;
               end else if (pop_ok) begin
                  present_ff[c_id[0]] <= 1'b0;
                  count_ff            <= count_ff - 1'b1;
               end
            end
            S_PLACE: begin
               state_ff <= S_REPLY;
            end
            S_REPLY: begin
               if (rsp_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
      // hold request payload
      if (req_xfer) begin
         mode_ff <= req_mode;
         idx_ff  <= id_ok ? req_entry_id[IW-1:0] : '0;
         idok_ff <= id_ok;
         np_ff   <= req_new_priority;
      end
      if ((state_ff == S_REPLY) && rsp_free) begin
         rsp_ok_ff    <= ok_ff;
         rsp_id_ff    <= oid_ff;
         rsp_prio_ff  <= opr_ff;
         rsp_count_ff <= 9'(count_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_out_id       = rsp_id_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_entry_count  = rsp_count_ff;

endmodule

[tb/indexed_priority_queue_tb.sv]
module indexed_priority_queue_tb;
   import ipq_pkg::*;

   localparam int CAPACITY = DEF_MAX_ENTRIES;
   localparam logic signed [31:0] PRIO_CEILING = 32'sd256000000;

   typedef struct {
      logic              ok;
      logic [7:0]        out_id;
      logic signed [31:0] out_priority;
      logic [8:0]        entry_count;
   } outcome_type;

   // shadow of the queue: ordering, priorities, presence and the id bound
   class queue_scoreboard;
      int unsigned       order[$];
      logic signed [31:0] prio[CAPACITY];
      bit                present[CAPACITY];
      int unsigned       active_bound;
      outcome_type       pending[$];
      int                errors;

      function void clear();
         order.delete();
         pending.delete();
         foreach (present[i]) present[i] = 0;
         active_bound = CSR_RESET;
         errors = 0;
      endfunction

      function void set_bound(logic [8:0] v);
         active_bound = int'(v);
      endfunction

      // insert before the first entry whose priority is at or below its own
      function void place(int unsigned id);
         int k;
         k = 0;
         while (k < order.size() && prio[order[k]] > prio[id]) k++;
         order.insert(k, id);
      endfunction

      function void unplace(int unsigned id);
         foreach (order[k])
            if (order[k] == id) begin
               order.delete(k);
               return;
            end
      endfunction

      // note an accepted request and queue its expected response
      function void note_request(logic [2:0] mode, logic signed [10:0] id,
                                 logic signed [31:0] np);
         outcome_type r;
         bit id_ok;
         int unsigned u;
         r = '{0, 0, 0, 0};
         id_ok = id >= 0 && int'(id) < int'(active_bound) && int'(id) < CAPACITY;
         u = id_ok ? int'(id) : 0;
         case (mode)
            MODE_INSERT: begin
               if (id_ok && !present[u] && np < PRIO_CEILING) begin
                  prio[u] = np;
                  present[u] = 1;
                  place(u);
                  r.ok = 1;
               end
            end
            MODE_INCREASE, MODE_DECREASE: begin
               if (id_ok && present[u] && np < PRIO_CEILING &&
                   ((mode == MODE_INCREASE && np > prio[u]) ||
                    (mode == MODE_DECREASE && np < prio[u]))) begin
                  unplace(u);
                  prio[u] = np;
                  place(u);
                  r.ok = 1;
               end
            end
            MODE_REMOVE: begin
               if (order.size() > 0) begin
                  u = order.pop_front();
                  present[u] = 0;
                  r.out_id = u[7:0];
                  r.out_priority = prio[u];
                  r.ok = 1;
               end
            end
            MODE_QUERY: begin
               if (id_ok && present[u]) begin
                  r.out_priority = prio[u];
                  r.ok = 1;
               end
            end
            default: ;
         endcase
         r.entry_count = 9'(order.size());
         pending.push_back(r);
      endfunction

      // compare a response against the oldest expectation
      function void check_response(outcome_type a);
         outcome_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response ok=%0d id=%0d prio=%0d count=%0d",
                     $time, a.ok, a.out_id, a.out_priority, a.entry_count);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.ok !== e.ok) begin
            $display("%0t: ok expected %0d actual %0d", $time, e.ok, a.ok);
            errors++;
         end
         if (a.out_id !== e.out_id) begin
            $display("%0t: out_id expected %0d actual %0d", $time, e.out_id, a.out_id);
            errors++;
         end
         if (a.out_priority !== e.out_priority) begin
            $display("%0t: out_priority expected %0d actual %0d",
                     $time, e.out_priority, a.out_priority);
            errors++;
         end
         if (a.entry_count !== e.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, e.entry_count, a.entry_count);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               csr_write = 0;
   logic [8:0]         csr_active_entries = 0;
   logic               req_valid = 0;
   logic               req_stall;
   logic [2:0]         req_mode = 0;
   logic signed [10:0] req_entry_id = 0;
   logic signed [31:0] req_new_priority = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic               rsp_ok;
   logic [7:0]         rsp_out_id;
   logic signed [31:0] rsp_out_priority;
   logic [8:0]         rsp_entry_count;

   queue_scoreboard board;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_off_cycles = 0;
   int  bound_now = CSR_RESET;

   indexed_priority_queue dut (
      .clock, .reset, .csr_write, .csr_active_entries,
      .req_valid, .req_stall, .req_mode, .req_entry_id, .req_new_priority,
      .rsp_valid, .rsp_stall, .rsp_ok, .rsp_out_id, .rsp_out_priority,
      .rsp_entry_count
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // stall the response channel at random, or hold off for a long stretch
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // check every response transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response('{rsp_ok, rsp_out_id, rsp_out_priority, rsp_entry_count});
   end

   // offer one request and hold it until transferred
   task automatic send(logic [2:0] mode, logic signed [10:0] id, logic signed [31:0] np);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_mode <= mode;
      req_entry_id <= id;
      req_new_priority <= np;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(mode, id, np);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_bound(logic [8:0] v);
      drain();
      csr_write <= 1;
      csr_active_entries <= v;
      @(negedge clock);
      csr_write <= 0;
      board.set_bound(v);
      bound_now = int'(v);
   endtask

   // mostly plausible priorities, with a few at the extremes and near the ceiling
   function automatic logic signed [31:0] pick_priority();
      case ($urandom_range(9))
         0: return $urandom;
         1: return PRIO_CEILING - 32'sd2 + $urandom_range(3);
         2: return 32'sh8000_0000 + $urandom_range(3);
         default: return $signed($urandom_range(64)) - 32'sd32;
      endcase
   endfunction

   function automatic logic signed [10:0] pick_id();
      int r;
      r = $urandom_range(19);
      if (r == 0) return 11'($urandom);
      if (r == 1) return 11'(bound_now + $urandom_range(2));
      return 11'($urandom_range((bound_now > 24 ? 24 : bound_now) - 1));
   endfunction

   task automatic random_burst(int n);
      int k;
      logic [2:0] m;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(19))
            0:            m = 3'(3'd5 + $urandom_range(2));
            1, 2, 3, 4, 5: m = MODE_INSERT;
            6, 7, 8:      m = MODE_INCREASE;
            9, 10, 11:    m = MODE_DECREASE;
            12, 13, 14, 15: m = MODE_REMOVE;
            default:      m = MODE_QUERY;
         endcase
         if (m == MODE_INCREASE || m == MODE_DECREASE)
            send(m, pick_id(), $signed($urandom_range(64)) - 32'sd32 +
                 ($urandom_range(9) == 0 ? pick_priority() : 0));
         else
            send(m, pick_id(), pick_priority());
      end
   endtask

   initial begin
      int k;
      board = new();
      board.clear();
      repeat (12) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: extremes, every operation and each rejection case
      send(MODE_REMOVE, 0, 0);
      send(MODE_INSERT, 0, 32'sh8000_0000);
      send(MODE_INSERT, 255, PRIO_CEILING - 1);
      send(MODE_INSERT, 7, PRIO_CEILING);
      send(MODE_INSERT, 8, 32'sh7fff_ffff);
      send(MODE_INSERT, -1, 5);
      send(MODE_INSERT, -1024, 5);
      send(MODE_INSERT, 1023, 5);
      send(MODE_INSERT, 256, 5);
      send(MODE_INSERT, 0, 5);
      send(MODE_INSERT, 3, 5);
      send(MODE_INSERT, 4, 5);
      send(MODE_INCREASE, 3, 5);
      send(MODE_INCREASE, 3, 6);
      send(MODE_DECREASE, 3, 6);
      send(MODE_DECREASE, 3, 5);
      send(MODE_INCREASE, 9, 50);
      send(MODE_DECREASE, 4, PRIO_CEILING);
      send(MODE_QUERY, 255, 0);
      send(MODE_QUERY, 9, 0);
      send(3'd5, 3, 1);
      send(3'd7, 3, 1);
      for (k = 0; k < 5; k++) send(MODE_REMOVE, 0, 0);

      // shrink the bound: high ids stay queued and still come out
      send(MODE_INSERT, 200, 1);
      write_bound(1);
      send(MODE_QUERY, 200, 0);
      send(MODE_INSERT, 0, 2);
      send(MODE_INSERT, 1, 2);
      random_burst(40);

      // idling phases across several bounds
      write_bound(256);
      random_burst(300);
      write_bound(16);
      send_idle_pct = 55;
      random_burst(300);
      write_bound(5);
      send_idle_pct = 0;
      recv_stall_pct = 55;
      random_burst(300);
      write_bound(2);
      send_idle_pct = 22;
      recv_stall_pct = 22;
      random_burst(200);
      write_bound(0);
      random_burst(20);

      // long hold-off: fill the pipeline until the input stalls
      write_bound(24);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 200;
      random_burst(40);
      drain();
      random_burst(200);
      write_bound(256);
      send_idle_pct = 22;
      recv_stall_pct = 22;
      random_burst(300);
      drain();
      for (k = 0; k < 30; k++) send(MODE_REMOVE, 0, 0);
      drain();

      if (board.errors == 0 && board.pending.size() == 0)
         $display("indexed_priority_queue_tb OK");
      else
         $display("indexed_priority_queue_tb NOT OK");
      $finish;
   end

   initial begin
      #4000000;
      $display("indexed_priority_queue_tb NOT OK");
      $finish;
   end

endmodule
